// ----- rtl/cfrp_pkg.sv -----
// Package for the frame record parser: word types, result kinds,
// character codes and the decimal accumulate helpers. No dependencies.
package cfrp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Length of the "packet " header tag
  localparam logic [2:0] HDR_LEN = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } byte_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] rec_key;
    logic [31:0] rec_value;
    logic [31:0] rec_bias;
    logic [63:0] frame_number;
    logic [63:0] missed_total;
  } rec_word_t;

  // Parser result before the sequence counters are applied
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] rec_key;
    logic [31:0] rec_value;
    logic [31:0] rec_bias;
    logic [63:0] frame_number;
  } event_t;

  // Character of the header tag at a match position
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h70; // p
      3'd1: c = 8'h61; // a
      3'd2: c = 8'h63; // c
      3'd3: c = 8'h6B; // k
      3'd4: c = 8'h65; // e
      3'd5: c = 8'h74; // t
      3'd6: c = 8'h20; // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // acc * 10 + d as shift-add, clamped to all ones on 64-bit overflow
  function automatic logic [63:0] sat_mac10(input logic [63:0] acc, input logic [3:0] d);
    logic [67:0] s;
    s = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {64'd0, d};
    return (|s[67:64]) ? {64{1'b1}} : s[63:0];
  endfunction

  // acc * 10 + d modulo 2^32
  function automatic logic [31:0] wrap_mac10(input logic [31:0] acc, input logic [3:0] d);
    logic [31:0] s;
    s = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, d};
    return s;
  endfunction

endpackage

// ----- rtl/cfrp_parser.sv -----
// Byte parser: header match, frame number and record field accumulation.
// Depends on cfrp_pkg.
module cfrp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  cfrp_pkg::byte_word_t byte_word,
  output logic                ev_valid,
  input  logic                ev_ready,
  output cfrp_pkg::event_t    ev
);

  localparam logic [2:0] MODE_HDR_MATCH  = 3'd0;
  localparam logic [2:0] MODE_HDR_DIGITS = 3'd1;
  localparam logic [2:0] MODE_HDR_SKIP   = 3'd2;
  localparam logic [2:0] MODE_REC_DIGITS = 3'd3;
  localparam logic [2:0] MODE_REC_SKIP   = 3'd4;
  localparam logic [2:0] MODE_DONE       = 3'd5;

  logic [2:0]  mode, mode_p, mode_next;
  logic [2:0]  hpos, hpos_next;
  logic [63:0] frame_acc, frame_p, frame_next;
  logic [63:0] key_acc, key_p, key_next;
  logic [31:0] value_acc, value_p, value_next;
  logic [31:0] bias_acc, bias_p, bias_next;
  logic [1:0]  fpos, fpos_next;
  logic        lhc, lhc_p, lhc_next;
  logic        clr_line;
  logic        emit;
  logic [1:0]  emit_kind;
  logic        accept;
  logic        is_digit;
  logic [7:0]  digit_raw;
  logic [3:0]  digit;
  logic [7:0]  b;
  logic        last;
  cfrp_pkg::event_t ev_next;

  assign byte_ready = !ev_valid || ev_ready;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_word.data_byte;
  assign last       = byte_word.end_of_datagram;
  assign is_digit   = (b >= cfrp_pkg::CH_ZERO) && (b <= cfrp_pkg::CH_NINE);
  assign digit_raw  = b - cfrp_pkg::CH_ZERO;
  assign digit      = digit_raw[3:0];

  always_comb begin
    mode_p    = mode;
    hpos_next = hpos;
    frame_p   = frame_acc;
    key_p     = key_acc;
    value_p   = value_acc;
    bias_p    = bias_acc;
    fpos_next = fpos;
    lhc_p     = lhc;
    clr_line  = 1'b0;
    emit      = 1'b0;
    emit_kind = cfrp_pkg::KIND_RECORD;

    // Byte itself
    case (mode)
      MODE_HDR_MATCH: begin
        if (hpos < cfrp_pkg::HDR_LEN && b == cfrp_pkg::hdr_char(hpos)) begin
          hpos_next = hpos + 3'd1;
          if (hpos_next >= cfrp_pkg::HDR_LEN) begin
            mode_p = MODE_HDR_DIGITS;
          end
        end else begin
          mode_p    = MODE_DONE;
          emit      = 1'b1;
          emit_kind = cfrp_pkg::KIND_REJECT;
        end
      end
      MODE_HDR_DIGITS, MODE_HDR_SKIP: begin
        if (b == cfrp_pkg::CH_NL || b == cfrp_pkg::CH_NUL) begin
          mode_p    = (b == cfrp_pkg::CH_NUL) ? MODE_DONE : MODE_REC_DIGITS;
          clr_line  = 1'b1;
          emit      = 1'b1;
          emit_kind = cfrp_pkg::KIND_HEADER;
        end else if (mode == MODE_HDR_DIGITS && is_digit) begin
          frame_p = cfrp_pkg::sat_mac10(frame_acc, digit);
        end else begin
          mode_p = MODE_HDR_SKIP;
        end
      end
      MODE_REC_DIGITS, MODE_REC_SKIP: begin
        if (b == cfrp_pkg::CH_NUL) begin
          mode_p = MODE_DONE;
          emit   = lhc;
        end else if (b == cfrp_pkg::CH_NL) begin
          emit     = lhc;
          mode_p   = lhc ? MODE_REC_DIGITS : MODE_DONE;
          clr_line = 1'b1;
        end else begin
          lhc_p = 1'b1;
          if (b == cfrp_pkg::CH_COMMA) begin
            if (fpos < 2'd2) begin
              fpos_next = fpos + 2'd1;
              mode_p    = MODE_REC_DIGITS;
            end else begin
              mode_p = MODE_REC_SKIP;
            end
          end else if (mode == MODE_REC_DIGITS && is_digit) begin
            case (fpos)
              2'd0:    key_p   = cfrp_pkg::sat_mac10(key_acc, digit);
              2'd1:    value_p = cfrp_pkg::wrap_mac10(value_acc, digit);
              default: bias_p  = cfrp_pkg::wrap_mac10(bias_acc, digit);
            endcase
          end else begin
            mode_p = MODE_REC_SKIP;
          end
        end
      end
      default: begin
      end
    endcase

    lhc_next = clr_line ? 1'b0 : lhc_p;

    // Close out the datagram on its last byte
    if (last && !emit) begin
      case (mode_p)
        MODE_HDR_MATCH: begin
          emit      = 1'b1;
          emit_kind = cfrp_pkg::KIND_REJECT;
        end
        MODE_HDR_DIGITS, MODE_HDR_SKIP: begin
          emit      = 1'b1;
          emit_kind = cfrp_pkg::KIND_HEADER;
        end
        MODE_REC_DIGITS, MODE_REC_SKIP: begin
          emit      = lhc_next;
          emit_kind = cfrp_pkg::KIND_RECORD;
        end
        default: begin
        end
      endcase
    end

    ev_next.kind         = emit_kind;
    ev_next.rec_key      = (emit_kind == cfrp_pkg::KIND_RECORD) ? key_p : 64'd0;
    ev_next.rec_value    = (emit_kind == cfrp_pkg::KIND_RECORD) ? value_p : 32'd0;
    ev_next.rec_bias     = (emit_kind == cfrp_pkg::KIND_RECORD) ? bias_p : 32'd0;
    ev_next.frame_number = (emit_kind == cfrp_pkg::KIND_REJECT) ? 64'd0 : frame_p;

    if (last) begin
      mode_next  = MODE_HDR_MATCH;
      hpos_next  = 3'd0;
      frame_next = 64'd0;
      key_next   = 64'd0;
      value_next = 32'd0;
      bias_next  = 32'd0;
      fpos_next  = 2'd0;
      lhc_next   = 1'b0;
    end else begin
      mode_next  = mode_p;
      frame_next = frame_p;
      key_next   = clr_line ? 64'd0 : key_p;
      value_next = clr_line ? 32'd0 : value_p;
      bias_next  = clr_line ? 32'd0 : bias_p;
      if (clr_line) begin
        fpos_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_HDR_MATCH;
      hpos      <= 3'd0;
      frame_acc <= 64'd0;
      key_acc   <= 64'd0;
      value_acc <= 32'd0;
      bias_acc  <= 32'd0;
      fpos      <= 2'd0;
      lhc       <= 1'b0;
      ev_valid  <= 1'b0;
    end else begin
      if (accept) begin
        mode      <= mode_next;
        hpos      <= hpos_next;
        frame_acc <= frame_next;
        key_acc   <= key_next;
        value_acc <= value_next;
        bias_acc  <= bias_next;
        fpos      <= fpos_next;
        lhc       <= lhc_next;
        ev_valid  <= emit;
      end else if (ev_ready) begin
        ev_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      ev <= ev_next;
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_DONE |=> !ev_valid)
    else $error("event raised for a byte after parsing ended");

  a_datagram_restart: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> mode == MODE_HDR_MATCH && hpos == 3'd0 && !lhc)
    else $error("parser not restarted after last byte");

  a_hpos_range: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_HDR_MATCH |-> hpos < cfrp_pkg::HDR_LEN)
    else $error("header match position past tag length");

endmodule

// ----- rtl/cfrp_seq.sv -----
// Sequence tracker: frame gap detection and missed-frame total, two stages.
// Depends on cfrp_pkg.
module cfrp_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               ev_valid,
  output logic               ev_ready,
  input  cfrp_pkg::event_t   ev,
  output logic               rec_valid,
  input  logic               rec_ready,
  output cfrp_pkg::rec_word_t rec_word
);

  logic             gap_valid;
  cfrp_pkg::event_t gap_ev;
  logic             gap_gt;
  logic [63:0]      gap_diff;
  logic             gap_ready;
  logic             gap_load;
  logic             out_load;
  logic [63:0]      expected_frame;
  logic [63:0]      missed_count;
  logic [63:0]      missed_sum;
  logic             is_hdr;

  assign gap_ready = !rec_valid || rec_ready;
  assign ev_ready  = !gap_valid || gap_ready;
  assign gap_load  = ev_valid && ev_ready;
  assign out_load  = gap_valid && gap_ready;
  assign is_hdr    = (gap_ev.kind == cfrp_pkg::KIND_HEADER);
  assign missed_sum = missed_count + ((is_hdr && gap_gt) ? gap_diff : 64'd0);

  // Stage 1: compare against the expected frame
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_valid      <= 1'b0;
      expected_frame <= 64'd0;
    end else begin
      if (gap_load) begin
        gap_valid <= 1'b1;
        if (ev.kind == cfrp_pkg::KIND_HEADER) begin
          expected_frame <= ev.frame_number + 64'd1;
        end
      end else if (gap_ready) begin
        gap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gap_load) begin
      gap_ev   <= ev;
      gap_gt   <= ev.frame_number > expected_frame;
      gap_diff <= ev.frame_number - expected_frame;
    end
  end

  // Stage 2: accumulate the gap and hold the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid    <= 1'b0;
      missed_count <= 64'd0;
    end else begin
      if (out_load) begin
        rec_valid    <= 1'b1;
        missed_count <= missed_sum;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rec_word.kind         <= gap_ev.kind;
      rec_word.rec_key      <= gap_ev.rec_key;
      rec_word.rec_value    <= gap_ev.rec_value;
      rec_word.rec_bias     <= gap_ev.rec_bias;
      rec_word.frame_number <= gap_ev.frame_number;
      rec_word.missed_total <= missed_sum;
    end
  end

  a_missed_only_on_header: assert property (@(posedge clk) disable iff (rst)
    out_load && !is_hdr |=> missed_count == $past(missed_count))
    else $error("missed total moved on a non-header word");

  a_rec_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec_word))
    else $error("result word changed while waiting");

  a_gap_hold: assert property (@(posedge clk) disable iff (rst)
    gap_valid && !gap_ready |=> gap_valid && $stable(gap_ev))
    else $error("gap stage word changed while waiting");

endmodule

// ----- rtl/csv_frame_record_parser.sv -----
// Top level of the datagram frame/record parser.
// Depends on cfrp_pkg, cfrp_parser and cfrp_seq.
//
//   channel   dir  handshake              word
//   byte      in   byte_valid/byte_ready  cfrp_pkg::byte_word_t
//   rec       out  rec_valid/rec_ready    cfrp_pkg::rec_word_t
//
// Takes one byte per cycle while byte_ready is high; each byte yields zero or
// one result. A result passes, after its byte, through the parser event
// register, the gap compare stage, then the missed-total add and output.
// Reset (rst, synchronous) clears parse state, sequence counters and valids.
// A stall on rec backs up through the stages; byte_ready drops only when the
// parser event register is full and cannot advance.
module csv_frame_record_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  cfrp_pkg::byte_word_t byte_word,
  output logic                rec_valid,
  input  logic                rec_ready,
  output cfrp_pkg::rec_word_t rec_word
);

  logic             ev_valid;
  logic             ev_ready;
  cfrp_pkg::event_t ev;

  // Parse bytes into header, reject and record events
  cfrp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_word  (byte_word),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .ev         (ev)
  );

  // Apply frame sequence tracking and drive the result word
  cfrp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev        (ev),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_word  (rec_word)
  );

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> rec_word.kind == cfrp_pkg::KIND_RECORD ||
      rec_word.kind == cfrp_pkg::KIND_HEADER || rec_word.kind == cfrp_pkg::KIND_REJECT)
    else $error("result carries an undefined kind");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_word.kind == cfrp_pkg::KIND_REJECT |->
      rec_word.frame_number == 64'd0 && rec_word.rec_key == 64'd0)
    else $error("reject result carries frame or key data");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rec_valid |-> byte_ready)
    else $error("input stalled with an empty output register");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for csv_frame_record_parser: feeds datagram text bytes,
// predicts header, reject and record words in a local parser model, and
// checks every output word. Depends on cfrp_pkg and the parser RTL.
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_BYTES = 720;
  localparam int          LONG_HOLD    = 300;
  localparam int          SETTLE       = 16;
  localparam logic [55:0] TAG_TEXT     = "packet ";
  localparam string       JUNK         = "x\r ;.+-a";

  // Parser modes of the local model
  typedef enum logic [2:0] {
    TM_TAG, TM_FRAME, TM_FRAME_SKIP, TM_FIELDS, TM_FIELDS_SKIP, TM_DONE
  } text_mode_e;

  logic                 clk;
  logic                 rst;
  logic                 byte_valid;
  logic                 byte_ready;
  cfrp_pkg::byte_word_t byte_word;
  logic                 rec_valid;
  logic                 rec_ready = 1'b0;
  cfrp_pkg::rec_word_t  rec_word;

  csv_frame_record_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_word  (byte_word),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec_word   (rec_word)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------
  // Parser model state
  // ---------------------------------------------------------------------
  text_mode_e  tmode;
  logic [2:0]  tag_pos;
  logic [63:0] frame_sum;
  logic [63:0] key_sum;
  logic [31:0] value_sum;
  logic [31:0] bias_sum;
  logic [1:0]  comma_count;
  logic        line_live;
  logic [63:0] next_frame;
  logic [63:0] missed_sum;

  cfrp_pkg::rec_word_t parsed_results[$];
  int          error_count = 0;
  int          bytes_sent = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [7:0]  dgram[$];
  logic [63:0] next_send_frame = 64'd0;

  // Decimal accumulate for frame number and key; clamp at all ones
  function automatic logic [63:0] times_ten_sat(input logic [63:0] acc, input logic [3:0] d);
    logic [127:0] wide;
    wide = {64'd0, acc} * 10 + d;
    return (wide[127:64] != 64'd0) ? {64{1'b1}} : wide[63:0];
  endfunction

  // Build a result word; the missed total rides along in every kind
  function automatic cfrp_pkg::rec_word_t make_rec(input logic [1:0] k,
                                                   input logic [63:0] key,
                                                   input logic [31:0] v,
                                                   input logic [31:0] b,
                                                   input logic [63:0] f);
    cfrp_pkg::rec_word_t r;
    r.kind         = k;
    r.rec_key      = key;
    r.rec_value    = v;
    r.rec_bias     = b;
    r.frame_number = f;
    r.missed_total = missed_sum;
    return r;
  endfunction

  function automatic void clear_line();
    key_sum     = '0;
    value_sum   = '0;
    bias_sum    = '0;
    comma_count = '0;
    line_live   = 1'b0;
  endfunction

  function automatic void clear_dgram();
    tmode     = TM_TAG;
    tag_pos   = '0;
    frame_sum = '0;
    clear_line();
  endfunction

  // Accept the header: add any forward gap to the missed total, advance the
  // expected frame (wraps at 64 bits)
  function automatic cfrp_pkg::rec_word_t close_header();
    if (frame_sum > next_frame)
      missed_sum += frame_sum - next_frame;
    next_frame = frame_sum + 64'd1;
    return make_rec(cfrp_pkg::KIND_HEADER, '0, '0, '0, frame_sum);
  endfunction

  function automatic bit emit_line(output cfrp_pkg::rec_word_t r);
    if (!line_live)
      return 1'b0;
    r = make_rec(cfrp_pkg::KIND_RECORD, key_sum, value_sum, bias_sum, frame_sum);
    return 1'b1;
  endfunction

  function automatic bit scan_byte(input logic [7:0] b, output cfrp_pkg::rec_word_t r);
    logic       is_digit;
    logic [3:0] d;
    bit         got;
    is_digit = (b >= cfrp_pkg::CH_ZERO) && (b <= cfrp_pkg::CH_NINE);
    d = b[3:0];
    case (tmode)
      TM_TAG: begin
        if (b == TAG_TEXT[8 * (6 - tag_pos) +: 8]) begin
          tag_pos++;
          if (tag_pos == cfrp_pkg::HDR_LEN)
            tmode = TM_FRAME;
          return 1'b0;
        end
        // Any mismatch, newline or NUL rejects right away
        tmode = TM_DONE;
        r = make_rec(cfrp_pkg::KIND_REJECT, '0, '0, '0, '0);
        return 1'b1;
      end
      TM_FRAME, TM_FRAME_SKIP: begin
        if (b == cfrp_pkg::CH_NL || b == cfrp_pkg::CH_NUL) begin
          tmode = (b == cfrp_pkg::CH_NUL) ? TM_DONE : TM_FIELDS;
          clear_line();
          r = close_header();
          return 1'b1;
        end
        if (tmode == TM_FRAME && is_digit)
          frame_sum = times_ten_sat(frame_sum, d);
        else
          tmode = TM_FRAME_SKIP;
        return 1'b0;
      end
      TM_FIELDS, TM_FIELDS_SKIP: begin
        if (b == cfrp_pkg::CH_NUL) begin
          tmode = TM_DONE;
          return emit_line(r);
        end
        if (b == cfrp_pkg::CH_NL) begin
          // An empty line ends the datagram's text
          got = emit_line(r);
          tmode = line_live ? TM_FIELDS : TM_DONE;
          clear_line();
          return got;
        end
        line_live = 1'b1;
        if (b == cfrp_pkg::CH_COMMA) begin
          if (comma_count < 2'd2) begin
            comma_count++;
            tmode = TM_FIELDS;
          end else begin
            tmode = TM_FIELDS_SKIP;
          end
          return 1'b0;
        end
        if (tmode == TM_FIELDS && is_digit) begin
          if (comma_count == 2'd0)
            key_sum = times_ten_sat(key_sum, d);
          else if (comma_count == 2'd1)
            value_sum = value_sum * 32'd10 + 32'(d);
          else
            bias_sum = bias_sum * 32'd10 + 32'(d);
        end else begin
          tmode = TM_FIELDS_SKIP;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Model one accepted word; the last byte closes whatever is still open
  function automatic void parse_byte(input cfrp_pkg::byte_word_t w);
    cfrp_pkg::rec_word_t r;
    bit                  got;
    got = scan_byte(w.data_byte, r);
    if (w.end_of_datagram) begin
      if (!got) begin
        case (tmode)
          TM_TAG: begin
            r = make_rec(cfrp_pkg::KIND_REJECT, '0, '0, '0, '0);
            got = 1'b1;
          end
          TM_FRAME, TM_FRAME_SKIP: begin
            r = close_header();
            got = 1'b1;
          end
          TM_FIELDS, TM_FIELDS_SKIP: got = emit_line(r);
          default: got = 1'b0;
        endcase
      end
      clear_dgram();
    end
    if (got)
      parsed_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Output check: compare each accepted word with the oldest prediction
  // ---------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    cfrp_pkg::rec_word_t want;
    if (!rst && rec_valid && rec_ready) begin
      if (parsed_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0d key %h frame %h",
                 $time, rec_word.kind, rec_word.rec_key, rec_word.frame_number);
        error_count++;
      end else begin
        want = parsed_results.pop_front();
        compare_field("kind", 64'(want.kind), 64'(rec_word.kind));
        compare_field("rec_key", want.rec_key, rec_word.rec_key);
        compare_field("rec_value", 64'(want.rec_value), 64'(rec_word.rec_value));
        compare_field("rec_bias", 64'(want.rec_bias), 64'(rec_word.rec_bias));
        compare_field("frame_number", want.frame_number, rec_word.frame_number);
        compare_field("missed_total", want.missed_total, rec_word.missed_total);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Idle lengths: mostly short, a few long
  // ---------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)
      return $urandom_range(1, 3);
    if (r < 95)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: hold off for a long counted stretch on request, otherwise
  // stall at random while gaps are on
  always @(negedge clk) begin
    int stall_left;
    int hold_left;
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rec_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rec_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 99) < 25) begin
      stall_left = gap_len() - 1;
      rec_ready <= 1'b0;
    end else begin
      rec_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if it hangs
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one word at the falling edge, maybe after a gap; hold it until
  // accepted, then model it
  task automatic send_text_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 40) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      byte_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid = 1'b1;
    byte_word.data_byte       = b;
    byte_word.end_of_datagram = last;
    do @(posedge clk); while (!byte_ready);
    parse_byte(byte_word);
    bytes_sent++;
  endtask

  // Send the assembled datagram, flagging its final byte
  task automatic send_datagram();
    for (int i = 0; i < dgram.size(); i++)
      send_text_byte(dgram[i], i == dgram.size() - 1);
    dgram.delete();
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      dgram.push_back(s[i]);
  endfunction

  // Drop valid, then pause until every predicted word has arrived
  task automatic drain_results();
    @(negedge clk);
    byte_valid = 1'b0;
    while (parsed_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One field: mostly short numbers, some at or past the width limits,
  // sometimes empty, sometimes with a trailing non-digit
  function automatic void push_field();
    case ($urandom_range(0, 15))
      0: ;
      1: push_text($sformatf("%0d", $urandom));
      2: push_text($sformatf("%0d", {$urandom, $urandom}));
      3: push_text("18446744073709551615");
      4: push_text("99999999999999999999999");
      default: push_text($sformatf("%0d", $urandom_range(0, 999)));
    endcase
    if ($urandom_range(0, 7) == 0)
      dgram.push_back(JUNK[$urandom_range(0, JUNK.len() - 1)]);
  endfunction

  function automatic void push_noise(input int n);
    repeat (n) dgram.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Header line with a frame number that mostly follows the sequence
  function automatic void push_header();
    logic [63:0] v;
    int          r;
    r = $urandom_range(0, 19);
    if (r < 12)
      v = next_send_frame + 64'($urandom_range(0, 3));
    else if (r < 15)
      v = 64'($urandom_range(0, 50));
    else if (r < 17)
      v = {$urandom, $urandom};
    else
      v = {64{1'b1}} - 64'($urandom_range(0, 2));
    push_text("packet ");
    if (r == 18) begin
      v = '0;
    end else if (r == 19) begin
      push_text("99999999999999999999999");
      v = {64{1'b1}};
    end else begin
      push_text($sformatf("%0d", v));
    end
    if ($urandom_range(0, 7) == 0)
      push_text(" x9");
    dgram.push_back(cfrp_pkg::CH_NL);
    next_send_frame = v + 64'd1;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Bad tags: mismatch, newline or NUL in the tag, datagram too short
  task automatic test_header_rejects();
    push_text("x");
    send_datagram();
    push_text("pac\n1,2\n");
    send_datagram();
    push_text("pack");
    send_datagram();
    push_text("pa");
    dgram.push_back(cfrp_pkg::CH_NUL);
    send_datagram();
    push_text("Packet 1\n");
    send_datagram();
    drain_results();
  endtask

  // Header, a record, an empty line, then ignored text; header taken at the
  // last byte; digits cut by a non-digit in the header
  task automatic test_basic_records();
    push_text("packet 5\n1,2,3\n\n7,7\n");
    send_datagram();
    push_text("packet 6");
    send_datagram();
    push_text("packet 7x9\r\n");
    send_datagram();
    drain_results();
  endtask

  // Key saturation, value and bias wrap, final line without a newline
  task automatic test_number_limits();
    push_text("packet 8\n18446744073709551615,4294967295,0\n");
    push_text("18446744073709551616,4294967296,4294967301");
    send_datagram();
    drain_results();
  endtask

  // Missing fields, extra commas, non-digit stops, carriage return, NUL
  task automatic test_field_forms();
    push_text("packet 9\n12\n1,\n,5\n1,2,3,4,5\n12a3,4x,\r5\n\r\n9,9");
    dgram.push_back(cfrp_pkg::CH_NUL);
    push_text("1,1\n");
    send_datagram();
    push_text("packet 10");
    dgram.push_back(cfrp_pkg::CH_NUL);
    push_text("zz");
    send_datagram();
    dgram.push_back(8'hFF);
    send_datagram();
    drain_results();
  endtask

  // Forward gap, backward jump, top frame number with wrap of the next one
  task automatic test_frame_sequence();
    push_text("packet 20\n");
    send_datagram();
    push_text("packet 3\n");
    send_datagram();
    push_text("packet 18446744073709551615\n");
    send_datagram();
    push_text("packet 2\n");
    send_datagram();
    drain_results();
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming, so
  // the stages fill and byte_ready drops
  task automatic test_backpressure();
    gaps_on = 1'b0;
    @(posedge clk);
    hold_req = 1'b1;
    push_text("packet 30\n");
    repeat (40) push_text("3,4\n");
    send_datagram();
    drain_results();
    gaps_on = 1'b1;
    next_send_frame = 64'd31;
  endtask

  // Mostly well-formed datagrams with random content, the rest noise and
  // broken headers; idling switches off for some stretches
  task automatic test_random_datagrams();
    int stop_at;
    int lines;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        gaps_on = !gaps_on;
      if ($urandom_range(0, 9) < 7) begin
        push_header();
        lines = $urandom_range(0, 4);
        repeat (lines) begin
          repeat ($urandom_range(0, 3)) begin
            push_field();
            dgram.push_back(cfrp_pkg::CH_COMMA);
          end
          push_field();
          dgram.push_back(cfrp_pkg::CH_NL);
        end
        case ($urandom_range(0, 3))
          0: ;
          1: void'(dgram.pop_back());
          2: begin
            dgram.push_back(cfrp_pkg::CH_NL);
            push_noise($urandom_range(1, 4));
          end
          default: begin
            dgram.push_back(cfrp_pkg::CH_NUL);
            push_noise($urandom_range(0, 4));
          end
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: push_noise($urandom_range(1, 12));
          1: begin
            for (int i = 0; i < $urandom_range(0, 6); i++)
              dgram.push_back(TAG_TEXT[8 * (6 - i) +: 8]);
            push_noise($urandom_range(1, 6));
          end
          default: begin
            push_header();
            push_noise($urandom_range(1, 16));
          end
        endcase
      end
      send_datagram();
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_word  = '0;
    clear_dgram();
    next_frame = '0;
    missed_sum = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_header_rejects();
    test_basic_records();
    test_number_limits();
    test_field_forms();
    test_frame_sequence();
    test_backpressure();
    test_random_datagrams();

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cfrp_pkg.sv
rtl/cfrp_parser.sv
rtl/cfrp_seq.sv
rtl/csv_frame_record_parser.sv
tb/sv/testbench.sv
